// ===== hw/rtl/sset_pkg.sv =====
package sset_pkg;

	localparam int KEY_W    = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

	// What a cell shows its neighbours
	typedef struct packed {
		logic                    valid;
		logic signed [KEY_W-1:0] key;
		logic                    lt;
	} nbr_t;

	// Broadcast to every cell of the row
	typedef struct packed {
		logic                    ins_en;
		logic                    del_en;
		logic signed [KEY_W-1:0] key;
	} cmd_t;

endpackage

// ===== hw/rtl/sset_if.sv =====
interface sset_req_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  op;
	logic signed [sset_pkg::KEY_W-1:0]     key;

	modport source (output valid, output op, output key, input ready);
	modport sink   (input valid, input op, input key, output ready);
endinterface

interface sset_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [sset_pkg::STATUS_W-1:0]         status;
	logic [sset_pkg::COUNT_W-1:0]          entry_count;

	modport source (output valid, output status, output entry_count, input ready);
	modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ===== hw/rtl/sset_cell.sv =====
module sset_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  sset_pkg::cmd_t  cmd,
	input  sset_pkg::nbr_t  left,
	input  sset_pkg::nbr_t  right,
	output sset_pkg::nbr_t  self,
	output logic            eq
);

	logic                              valid_q;
	logic signed [sset_pkg::KEY_W-1:0] key_q;
	logic                              lt;

	assign lt = valid_q && ($signed(key_q) < $signed(cmd.key));
	assign eq = valid_q && (key_q == cmd.key);

	assign self.valid = valid_q;
	assign self.key   = key_q;
	assign self.lt    = lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins_en && !lt) begin
			valid_q <= left.lt ? 1'b1 : left.valid;
		end else if (cmd.del_en && !lt) begin
			valid_q <= right.valid;
		end
	end

	// Insert: the first cell not below the key takes it, the rest shift right.
	// Delete: every cell from the match onwards takes its right neighbour.
	always_ff @(posedge clk) begin
		if (cmd.ins_en && !lt) begin
			key_q <= left.lt ? cmd.key : left.key;
		end else if (cmd.del_en && !lt) begin
			key_q <= right.key;
		end
	end

endmodule

// ===== hw/rtl/sorted_set_insert_delete.sv =====
// A request transfer is first registered in the s1 registers, then its result in the rsp output registers.
// Throughput: one request per cycle unless an untaken result stalls rsp;
// every cell compares and shifts in the same cycle, so the next request
// sees the updated row at once. A delete on an empty set produces no result.
// Reset clears the valid flags, the key count and the handshake state;
// stored keys are left undefined.
module sorted_set_insert_delete #(
	parameter int CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	sset_req_if.sink          req,
	sset_rsp_if.source        rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic                              pend_s1;
	logic                              op_s1;
	logic signed [sset_pkg::KEY_W-1:0] key_s1;

	logic [CW-1:0]                     count_q;
	logic                              rsp_valid_q;
	logic [sset_pkg::STATUS_W-1:0]     status_q;
	logic [sset_pkg::COUNT_W-1:0]      entry_count_q;

	sset_pkg::nbr_t                    nbr [CAPACITY];
	logic [CAPACITY-1:0]               eq;
	logic [CAPACITY-1:0]               cell_valid;
	sset_pkg::cmd_t                    cmd;

	logic                              out_free;
	logic                              fire;
	logic                              hit;
	logic                              full;
	logic                              empty;
	logic [CW-1:0]                     count_next;
	logic [sset_pkg::STATUS_W-1:0]     status_next;
	logic [CW+sset_pkg::COUNT_W-1:0]   count_ext;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fire      = pend_s1 && out_free;
	assign req.ready = !pend_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (req.ready) begin
			pend_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1  <= req.op;
			key_s1 <= req.key;
		end
	end

	assign hit   = |eq;
	assign full  = cell_valid[CAPACITY-1];
	assign empty = !cell_valid[0];

	assign cmd.key    = key_s1;
	assign cmd.ins_en = fire && (op_s1 == sset_pkg::OP_INSERT) && !full && !hit;
	assign cmd.del_en = fire && (op_s1 == sset_pkg::OP_DELETE) && hit;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sset_pkg::nbr_t left_n;
		sset_pkg::nbr_t right_n;

		if (i == 0) begin : g_first
			// Sentinel below every key: cell 0 takes the key when nothing is smaller
			assign left_n = '{valid: 1'b0, key: '0, lt: 1'b1};
		end else begin : g_mid
			assign left_n = nbr[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_n = '{valid: 1'b0, key: '0, lt: 1'b0};
		end else begin : g_inner
			assign right_n = nbr[i+1];
		end

		sset_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (left_n),
			.right  (right_n),
			.self   (nbr[i]),
			.eq     (eq[i])
		);

		assign cell_valid[i] = nbr[i].valid;
	end

	always_comb begin
		count_next  = count_q;
		status_next = sset_pkg::ST_NOT_FOUND;
		if (op_s1 == sset_pkg::OP_INSERT) begin
			priority if (full) begin
				status_next = sset_pkg::ST_FULL;
			end else if (hit) begin
				status_next = sset_pkg::ST_DUPLICATE;
			end else begin
				status_next = sset_pkg::ST_INSERTED;
				count_next  = count_q + CW'(1);
			end
		end else if (hit) begin
			status_next = sset_pkg::ST_DELETED;
			count_next  = count_q - CW'(1);
		end
	end

	assign count_ext = {{sset_pkg::COUNT_W{1'b0}}, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_next;
			end
			// Drop the result of a delete on an empty set
			if (fire && !((op_s1 == sset_pkg::OP_DELETE) && empty)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= status_next;
			entry_count_q <= count_ext[sset_pkg::COUNT_W-1:0];
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = entry_count_q;

	a_count_matches_row: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("valid cells disagree with key count");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the count");

	a_full_refuses: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (op_s1 == sset_pkg::OP_INSERT) && full
		|=> rsp_valid_q && (status_q == sset_pkg::ST_FULL) && $stable(count_q))
		else $error("insert into full set not refused");

	a_result_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(fire))
		else $error("result without a request");

	a_no_ins_and_del: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del_en |-> !cmd.ins_en && !empty)
		else $error("conflicting row commands");

endmodule
